// ===== sv/ttts_pkg.sv =====
// ----------------------------------------------------------------------------
// ttts_pkg
// Shared types and constants for the time-triggered task scheduler: slot
// record layout, action codes and sizing of the slot ring.
// ----------------------------------------------------------------------------
`default_nettype none

package ttts_pkg;

  localparam int SLOTS      = 8;
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MAX_OUT    = 8;
  localparam int CNT_OUT_W  = $clog2(MAX_OUT + 1);
  localparam int IDX_W      = 4;
  localparam int TID_W      = 8;
  localparam int TIME_W     = 16;
  localparam int PEND_W     = 8;
  localparam int DEL_SLOT_W = 3;

  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_ADD      = 2'd1,
    ACT_DELETE   = 2'd2,
    ACT_DISPATCH = 2'd3
  } action_t;

  typedef struct packed {
    logic              used;
    logic [TID_W-1:0]  tid;
    logic [TIME_W-1:0] delay;
    logic [TIME_W-1:0] period;
    logic [PEND_W-1:0] pending;
  } slot_rec_t;

  // status from the head processor back to the sweep control
  typedef struct packed {
    logic add_hit;
    logic disp_hit;
  } head_stat_t;

endpackage

`default_nettype wire

// ===== sv/ttts_cell.sv =====
// ----------------------------------------------------------------------------
// ttts_cell
// One slot of the scheduler ring. Holds a slot record and takes the record
// of its neighbor whenever the ring advances.
// ----------------------------------------------------------------------------
`default_nettype none

module ttts_cell
  import ttts_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      shift,
  input  wire slot_rec_t rec_in,
  output slot_rec_t      rec_out
);

  slot_rec_t rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r <= '0;
    end else if (shift) begin
      rec_r <= rec_in;
    end
  end

  assign rec_out = rec_r;

endmodule

`default_nettype wire

// ===== sv/ttts_proc.sv =====
// ----------------------------------------------------------------------------
// ttts_proc
// Head processor of the slot ring. Applies the current action to the slot
// record leaving the head cell and returns the updated record to the tail.
// ----------------------------------------------------------------------------
`default_nettype none

module ttts_proc
  import ttts_pkg::*;
(
  input  wire action_t   action_i,
  input  wire slot_rec_t rec_i,
  input  wire slot_rec_t add_rec_i,
  input  wire logic      add_free_i,
  input  wire logic      del_hit_i,
  input  wire logic      disp_room_i,
  output slot_rec_t      rec_o,
  output head_stat_t     stat_o
);

  always_comb begin
    rec_o  = rec_i;
    stat_o = '0;
    unique case (action_i)
      ACT_TICK: begin
        if (rec_i.used) begin
          if (rec_i.delay == '0) begin
            if (rec_i.pending != '1) begin
              rec_o.pending = rec_i.pending + PEND_W'(1);
            end
            if (rec_i.period != '0) begin
              rec_o.delay = rec_i.period - TIME_W'(1);
            end
          end else begin
            rec_o.delay = rec_i.delay - TIME_W'(1);
          end
        end
      end
      ACT_ADD: begin
        if (add_free_i && !rec_i.used) begin
          rec_o          = add_rec_i;
          stat_o.add_hit = 1'b1;
        end
      end
      ACT_DELETE: begin
        if (del_hit_i) begin
          rec_o = '0;
        end
      end
      ACT_DISPATCH: begin
        if (disp_room_i && rec_i.used && (rec_i.pending != '0)) begin
          stat_o.disp_hit = 1'b1;
          rec_o.pending   = rec_i.pending - PEND_W'(1);
          // free one-shot tasks once they have run
          if (rec_i.period == '0) begin
            rec_o = '0;
          end
        end
      end
      default: begin
        rec_o = rec_i;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/time_triggered_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// time_triggered_task_scheduler
// Cooperative task scheduler over a ring of slot cells. Each transaction
// rotates the whole ring once through a single head processor.
//
//   channel  ports                                         handshake
//   input    in_action in_task_id in_first_delay
//            in_repeat_period in_slot                      start & !busy
//   result   out_slot_index out_run_task_id out_task_ran
//            out_last                                      out_strobe
//
// A transaction keeps busy high while the ring rotates past the head
// processor slot by slot, and then while the final result is issued; a
// new transaction is accepted only once busy has dropped.
// Dispatch results appear one per cycle at most, each one strobe cycle;
// tick and delete give no result. Reset is synchronous and clears all slots
// at once. The receiver cannot stall the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module time_triggered_task_scheduler
  import ttts_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            in_action,
  input  wire logic [TID_W-1:0]      in_task_id,
  input  wire logic [TIME_W-1:0]     in_first_delay,
  input  wire logic [TIME_W-1:0]     in_repeat_period,
  input  wire logic [DEL_SLOT_W-1:0] in_slot,
  output logic                       out_strobe,
  output logic [IDX_W-1:0]           out_slot_index,
  output logic [TID_W-1:0]           out_run_task_id,
  output logic                       out_task_ran,
  output logic                       out_last
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_DONE  = 3'b100
  } state_t;

  state_t                  state_r, state_nxt;
  logic [SLOT_W-1:0]       cnt_r, cnt_nxt;
  logic [CNT_OUT_W-1:0]    nout_r, nout_nxt;
  logic                    held_v_r, held_v_nxt;
  logic [SLOT_W-1:0]       held_idx_r, held_idx_nxt;
  logic [TID_W-1:0]        held_id_r, held_id_nxt;

  action_t                 action_r, action_nxt;
  slot_rec_t               add_rec_r, add_rec_nxt;
  logic [DEL_SLOT_W-1:0]   del_slot_r, del_slot_nxt;

  logic                    strobe_r, strobe_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [TID_W-1:0]        rid_r, rid_nxt;
  logic                    ran_r, ran_nxt;
  logic                    last_r, last_nxt;

  logic                    shift;
  logic                    accept;
  logic                    del_hit;
  logic                    disp_room;
  slot_rec_t               ring [SLOTS];
  slot_rec_t               head_out;
  head_stat_t              head_stat;

  // --- slot ring -----------------------------------------------------------
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    slot_rec_t cell_in;
    if (i == SLOTS - 1) begin : g_tail
      assign cell_in = head_out;
    end else begin : g_mid
      assign cell_in = ring[i+1];
    end
    ttts_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift   (shift),
      .rec_in  (cell_in),
      .rec_out (ring[i])
    );
  end

  assign del_hit   = (32'(del_slot_r) == 32'(cnt_r));
  assign disp_room = (nout_r < CNT_OUT_W'(MAX_OUT));

  ttts_proc u_proc (
    .action_i    (action_r),
    .rec_i       (ring[0]),
    .add_rec_i   (add_rec_r),
    .add_free_i  (!held_v_r),
    .del_hit_i   (del_hit),
    .disp_room_i (disp_room),
    .rec_o       (head_out),
    .stat_o      (head_stat)
  );

  // --- sweep control -------------------------------------------------------
  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign shift  = (state_r == ST_SWEEP);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    nout_nxt     = nout_r;
    held_v_nxt   = held_v_r;
    held_idx_nxt = held_idx_r;
    held_id_nxt  = held_id_r;
    action_nxt   = action_r;
    add_rec_nxt  = add_rec_r;
    del_slot_nxt = del_slot_r;
    strobe_nxt   = 1'b0;
    idx_nxt      = idx_r;
    rid_nxt      = rid_r;
    ran_nxt      = ran_r;
    last_nxt     = last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt           = ST_SWEEP;
          cnt_nxt             = '0;
          nout_nxt            = '0;
          held_v_nxt          = 1'b0;
          action_nxt          = action_t'(in_action);
          add_rec_nxt.used    = 1'b1;
          add_rec_nxt.tid     = in_task_id;
          add_rec_nxt.delay   = in_first_delay;
          add_rec_nxt.period  = in_repeat_period;
          add_rec_nxt.pending = '0;
          del_slot_nxt        = in_slot;
        end
      end
      ST_SWEEP: begin
        if (head_stat.add_hit) begin
          held_v_nxt   = 1'b1;
          held_idx_nxt = cnt_r;
          held_id_nxt  = '0;
        end
        if (head_stat.disp_hit) begin
          nout_nxt = nout_r + CNT_OUT_W'(1);
          // issue the previous ready task; the newest one waits for last
          if (held_v_r) begin
            strobe_nxt = 1'b1;
            idx_nxt    = IDX_W'(held_idx_r);
            rid_nxt    = held_id_r;
            ran_nxt    = 1'b1;
            last_nxt   = 1'b0;
          end
          held_v_nxt   = 1'b1;
          held_idx_nxt = cnt_r;
          held_id_nxt  = ring[0].tid;
        end
        if (cnt_r == SLOT_W'(SLOTS - 1)) begin
          state_nxt = ST_DONE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + SLOT_W'(1);
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
        if ((action_r == ACT_ADD) || (action_r == ACT_DISPATCH)) begin
          strobe_nxt = 1'b1;
          idx_nxt    = held_v_r ? IDX_W'(held_idx_r) : IDX_W'(SLOTS);
          rid_nxt    = held_v_r ? held_id_r : '0;
          ran_nxt    = held_v_r && (action_r == ACT_DISPATCH);
          last_nxt   = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      nout_r   <= '0;
      held_v_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      nout_r   <= nout_nxt;
      held_v_r <= held_v_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_idx_r <= held_idx_nxt;
    held_id_r  <= held_id_nxt;
    action_r   <= action_nxt;
    add_rec_r  <= add_rec_nxt;
    del_slot_r <= del_slot_nxt;
    idx_r      <= idx_nxt;
    rid_r      <= rid_nxt;
    ran_r      <= ran_nxt;
    last_r     <= last_nxt;
  end

  assign out_strobe      = strobe_r;
  assign out_slot_index  = idx_r;
  assign out_run_task_id = rid_r;
  assign out_task_ran    = ran_r;
  assign out_last        = last_r;

endmodule

`default_nettype wire
